// File: design/lr_pkg.sv
`timescale 1ns / 1ps
// shared constants for the line rasterizer
// no dependencies

package lr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int GLYPH_BITS     = 8;
    localparam int BYTE_BITS      = 8;

endpackage

// File: design/line_rasterizer_unit.sv
`timescale 1ns / 1ps
// line rasterizer top level: walks one line command into pixel writes
// depends on lr_pkg
//
// usage:
//   s_axis carries one line command per transaction; it is accepted only
//   while the unit is idle (s_axis_tready high).
//   m_axis carries one pixel write per transaction; m_axis_tlast marks the
//   final pixel of the line.
// sequence and throughput:
//   after acceptance come the setup states, span then orientation, and then one
//   pixel per cycle through the shared error-term adder while the receiver
//   takes them. n, the pixel count of a line, is the major-axis span plus
//   one, up to 2^COORD_BITS.
//   the next command is accepted in the cycle after the last pixel is
//   loaded, even while that pixel still waits in the output register.
// reset:
//   rst_n clears the sequencer and the output valid; the unit comes up idle.
// stalls:
//   a pixel held in the output register stays stable until taken, and the
//   walk pauses; nothing is lost or repeated.

module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // x_start, y_start, x_end, y_end, glyph, zero pad
    input  logic [((4*COORD_BITS+GLYPH_BITS+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pix_x, pix_y, pix_glyph, zero pad
    output logic [((2*COORD_BITS+GLYPH_BITS+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 4;
    localparam int OUT_USED = 2*COORD_BITS + GLYPH_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_ORIENT,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    logic [C-1:0]          xa_reg, xa_next, ya_reg, ya_next;
    logic [C-1:0]          xb_reg, xb_next, yb_reg, yb_next;
    logic [GLYPH_BITS-1:0] glyph_reg, glyph_next;
    logic [C-1:0]          adx_reg, adx_next, ady_reg, ady_next;
    logic [C-1:0]          major_pos_reg, major_pos_next;
    logic [C-1:0]          minor_pos_reg, minor_pos_next;
    logic [C-1:0]          major_stop_reg, major_stop_next;
    logic signed [E-1:0]   err_reg, err_next;
    logic signed [E-1:0]   inc_flat_reg, inc_flat_next;
    logic signed [E-1:0]   inc_diag_reg, inc_diag_next;
    logic                  minor_down_reg, minor_down_next;
    logic                  steep_reg, steep_next;
    logic [C-1:0]          pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic [GLYPH_BITS-1:0] pix_glyph_reg, pix_glyph_next;
    logic                  last_reg, last_next;

    logic                  in_fire;
    logic                  out_free;
    logic                  steep_c;
    logic [C-1:0]          ma, mb, na, nb;
    logic [C-1:0]          dmaj, dmin;
    logic signed [E-1:0]   flat_c, dmaj2_c;
    logic                  fin;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign fin      = (major_pos_reg == major_stop_reg);

    // orientation and endpoint swap
    always_comb
    begin
        steep_c = !(ady_reg < adx_reg);
        if (steep_c)
        begin
            ma = ya_reg; mb = yb_reg; na = xa_reg; nb = xb_reg;
            dmaj = ady_reg; dmin = adx_reg;
        end
        else
        begin
            ma = xa_reg; mb = xb_reg; na = ya_reg; nb = yb_reg;
            dmaj = adx_reg; dmin = ady_reg;
        end
        if (ma > mb)
        begin
            {ma, mb} = {mb, ma};
            {na, nb} = {nb, na};
        end
        flat_c  = signed'({{(E-C-1){1'b0}}, dmin, 1'b0});
        dmaj2_c = signed'({{(E-C-1){1'b0}}, dmaj, 1'b0});
    end

    always_comb
    begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        xa_next         = xa_reg;
        ya_next         = ya_reg;
        xb_next         = xb_reg;
        yb_next         = yb_reg;
        glyph_next      = glyph_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        major_stop_next = major_stop_reg;
        err_next        = err_reg;
        inc_flat_next   = inc_flat_reg;
        inc_diag_next   = inc_diag_reg;
        minor_down_next = minor_down_reg;
        steep_next      = steep_reg;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        pix_glyph_next  = pix_glyph_reg;
        last_next       = last_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    xa_next    = s_axis_tdata[C-1:0];
                    ya_next    = s_axis_tdata[2*C-1:C];
                    xb_next    = s_axis_tdata[3*C-1:2*C];
                    yb_next    = s_axis_tdata[4*C-1:3*C];
                    glyph_next = s_axis_tdata[4*C+GLYPH_BITS-1:4*C];
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                adx_next   = (xa_reg > xb_reg) ? xa_reg - xb_reg : xb_reg - xa_reg;
                ady_next   = (ya_reg > yb_reg) ? ya_reg - yb_reg : yb_reg - ya_reg;
                state_next = ST_ORIENT;
            end
            ST_ORIENT:
            begin
                steep_next      = steep_c;
                major_pos_next  = ma;
                major_stop_next = mb;
                minor_pos_next  = na;
                minor_down_next = nb < na;
                inc_flat_next   = flat_c;
                inc_diag_next   = flat_c - dmaj2_c;
                err_next        = flat_c - signed'({{(E-C){1'b0}}, dmaj});
                state_next      = ST_WALK;
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    pix_x_next     = steep_reg ? minor_pos_reg : major_pos_reg;
                    pix_y_next     = steep_reg ? major_pos_reg : minor_pos_reg;
                    pix_glyph_next = glyph_reg;
                    last_next      = fin;
                    // shared error-term adder
                    if (err_reg > 0)
                    begin
                        minor_pos_next = minor_down_reg ? minor_pos_reg - C'(1)
                                                        : minor_pos_reg + C'(1);
                        err_next       = err_reg + inc_diag_reg;
                    end
                    else
                    begin
                        err_next = err_reg + inc_flat_reg;
                    end
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        major_pos_next = major_pos_reg + C'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            xa_reg         <= '0;
            ya_reg         <= '0;
            xb_reg         <= '0;
            yb_reg         <= '0;
            glyph_reg      <= '0;
            adx_reg        <= '0;
            ady_reg        <= '0;
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            major_stop_reg <= '0;
            err_reg        <= '0;
            inc_flat_reg   <= '0;
            inc_diag_reg   <= '0;
            minor_down_reg <= 1'b0;
            steep_reg      <= 1'b0;
            pix_x_reg      <= '0;
            pix_y_reg      <= '0;
            pix_glyph_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            xa_reg         <= xa_next;
            ya_reg         <= ya_next;
            xb_reg         <= xb_next;
            yb_reg         <= yb_next;
            glyph_reg      <= glyph_next;
            adx_reg        <= adx_next;
            ady_reg        <= ady_next;
            major_pos_reg  <= major_pos_next;
            minor_pos_reg  <= minor_pos_next;
            major_stop_reg <= major_stop_next;
            err_reg        <= err_next;
            inc_flat_reg   <= inc_flat_next;
            inc_diag_reg   <= inc_diag_next;
            minor_down_reg <= minor_down_next;
            steep_reg      <= steep_next;
            pix_x_reg      <= pix_x_next;
            pix_y_reg      <= pix_y_next;
            pix_glyph_reg  <= pix_glyph_next;
            last_reg       <= last_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[OUT_USED-1:0] = {pix_glyph_reg, pix_y_reg, pix_x_reg};
    end

    // idle means the output holds nothing or the final pixel of a line
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("idle with a non-final pixel pending");

    // a command transaction starts the setup sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SPAN))
        else $error("accepted command did not start setup");

    // the walk never passes the stop coordinate
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (major_pos_reg <= major_stop_reg))
        else $error("major position beyond stop");

    // when the walk ends, the final pixel loads flagged and the unit goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && out_free && fin) |=> (m_axis_tlast && s_axis_tready))
        else $error("final pixel not flagged on walk end");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for line_rasterizer_unit: line commands in, pixel writes out
// predicts every pixel with its own bresenham walk; depends on lr_pkg and the rtl

module tb;

    import lr_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int CMD_W    = ((4*CB+GLYPH_BITS+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS;
    localparam int PIX_W    = ((2*CB+GLYPH_BITS+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS;
    localparam int N_RANDOM = 280;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [CB-1:0]         x_start;
        logic [CB-1:0]         y_start;
        logic [CB-1:0]         x_end;
        logic [CB-1:0]         y_end;
        logic [GLYPH_BITS-1:0] glyph;
    } line_cmd_t;

    typedef struct packed {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [GLYPH_BITS-1:0] glyph;
        logic                  last;
    } pixel_t;

    class line_scoreboard;
        pixel_t pending_pixels[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // walk the line the way the unit should and queue its pixel writes
        function void note_line(line_cmd_t c);
            int                   dx;
            int                   dy;
            bit                   steep;
            bit                   down;
            bit                   done;
            logic [CB-1:0]        ma;
            logic [CB-1:0]        mb;
            logic [CB-1:0]        na;
            logic [CB-1:0]        nb;
            logic [CB-1:0]        t;
            logic [CB:0]          dmaj;
            logic [CB:0]          dmin;
            logic signed [9:0]    err;
            pixel_t               p;
            dx = (c.x_start > c.x_end) ? c.x_start - c.x_end : c.x_end - c.x_start;
            dy = (c.y_start > c.y_end) ? c.y_start - c.y_end : c.y_end - c.y_start;
            steep = !(dy < dx);
            if (steep)
            begin
                ma = c.y_start; mb = c.y_end; na = c.x_start; nb = c.x_end;
            end
            else
            begin
                ma = c.x_start; mb = c.x_end; na = c.y_start; nb = c.y_end;
            end
            if (ma > mb)
            begin
                t = ma; ma = mb; mb = t;
                t = na; na = nb; nb = t;
            end
            dmaj = mb - ma;
            dmin = (na > nb) ? na - nb : nb - na;
            down = nb < na;
            err  = 10'(2 * int'(dmin) - int'(dmaj));
            done = 0;
            while (!done)
            begin
                done    = (ma == mb);
                p.x     = steep ? na : ma;
                p.y     = steep ? ma : na;
                p.glyph = c.glyph;
                p.last  = done;
                pending_pixels.push_back(p);
                if (err > 0)
                begin
                    na  = down ? na - CB'(1) : na + CB'(1);
                    err = err + 10'(2 * (int'(dmin) - int'(dmaj)));
                end
                else
                begin
                    err = err + 10'(2 * int'(dmin));
                end
                ma = ma + CB'(1);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d glyph=%0h last=%0b",
                       got.x, got.y, got.glyph, got.last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x)
            begin
                $error("pix_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("pix_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.glyph !== want.glyph)
            begin
                $error("pix_glyph: expected %0h, got %0h", want.glyph, got.glyph);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // x_start, y_start, x_end, y_end, glyph, zero pad
    logic [CMD_W-1:0] s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // pix_x, pix_y, pix_glyph, zero pad
    logic [PIX_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    line_scoreboard sb;

    line_rasterizer_unit #(
        .COORD_BITS (CB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 19);
        if (calm)
            return 0;
        if (r < 14)
            return $urandom_range(0, 3);
        if (r < 18)
            return $urandom_range(4, 8);
        return $urandom_range(10, 20);
    endfunction

    function automatic line_cmd_t mk_line(int xs, int ys, int xe, int ye, int g);
        line_cmd_t c;
        c.x_start = CB'(xs);
        c.y_start = CB'(ys);
        c.x_end   = CB'(xe);
        c.y_end   = CB'(ye);
        c.glyph   = GLYPH_BITS'(g);
        return c;
    endfunction

    function automatic line_cmd_t random_line();
        line_cmd_t c;
        int        kind;
        int        d;
        kind = $urandom_range(0, 7);
        c = mk_line($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
        d = $urandom_range(0, 63);
        case (kind)
            0: c.x_end = c.x_start;
            1: c.y_end = c.y_start;
            2, 3:
            begin
                c.x_end = c.x_start + CB'($urandom_range(0, 14)) - CB'(7);
                c.y_end = c.y_start + CB'($urandom_range(0, 14)) - CB'(7);
            end
            4:
            begin
                c.x_end = c.x_start + CB'(d);
                c.y_end = $urandom_range(0, 1) ? c.y_start + CB'(d) : c.y_start - CB'(d);
            end
            default: ;
        endcase
        return c;
    endfunction

    // tvalid stays high across back-to-back transactions
    task automatic send_line(line_cmd_t c, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= CMD_W'({c.glyph, c.y_end, c.x_end, c.y_start, c.x_start});
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_line(c);
    endtask

    task automatic run_directed();
        send_line(mk_line(0, 0, 0, 0, 8'h00), 0);
        send_line(mk_line(63, 63, 63, 63, 8'hff), 0);
        send_line(mk_line(5, 0, 5, 63, 8'h41), idle_len(0));
        send_line(mk_line(5, 63, 5, 0, 8'h42), idle_len(0));
        send_line(mk_line(0, 10, 63, 10, 8'haa), idle_len(0));
        send_line(mk_line(63, 10, 0, 10, 8'h55), 0);
        send_line(mk_line(0, 0, 63, 63, 8'h01), idle_len(0));
        send_line(mk_line(63, 0, 0, 63, 8'h80), idle_len(0));
        send_line(mk_line(0, 63, 63, 0, 8'h7f), 0);
        send_line(mk_line(10, 10, 20, 20, 8'h23), idle_len(0));
        send_line(mk_line(0, 0, 63, 1, 8'h2e), idle_len(0));
        send_line(mk_line(0, 0, 1, 63, 8'h7c), 0);
        send_line(mk_line(0, 63, 63, 30, 8'h2f), idle_len(0));
        send_line(mk_line(40, 50, 30, 3, 8'h5c), idle_len(0));
        send_line(mk_line(0, 0, 10, 9, 8'h3d), 0);
        send_line(mk_line(10, 9, 0, 0, 8'h3e), idle_len(0));
        send_line(mk_line(3, 7, 12, 17, 8'h3c), idle_len(0));
        send_line(mk_line(63, 63, 0, 0, 8'hc3), 0);
        send_line(mk_line(62, 1, 1, 62, 8'h3c), idle_len(0));
        send_line(mk_line(33, 33, 34, 32, 8'h18), 0);
        send_line(mk_line(63, 0, 0, 1, 8'he7), idle_len(0));
    endtask

    // pixel sink with random backpressure and calm stretches
    initial
    begin
        int stall_left;
        int phase_left;
        bit calm;
        m_axis_tready = 1'b0;
        stall_left = 0;
        phase_left = 0;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    stall_left = idle_len(0) + 1;
            end
        end
    end

    initial
    begin
        pixel_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.x     = m_axis_tdata[CB-1:0];
                got.y     = m_axis_tdata[2*CB-1:CB];
                got.glyph = m_axis_tdata[2*CB+GLYPH_BITS-1:2*CB];
                got.last  = m_axis_tlast;
                sb.check_pixel(got);
            end
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        bit calm;
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        calm = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_line(random_line(), idle_len(calm));
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
